@@ rtl/core/bbp_pkg.sv @@
// Shared widths, payload types and handshake structs for the bicubic Bezier patch evaluator.
package bbp_pkg;

    localparam int COORD_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int PARAM_W    = FRAC_W + 1;
    localparam int PARAM3_W   = FRAC_W + 2;
    localparam int NUM_POINTS = 16;
    localparam int NUM_AXES   = 3;
    localparam int IDX_W      = $clog2(NUM_POINTS);
    localparam int AXIS_W     = $clog2(NUM_AXES);
    localparam int WGT_W      = 2 * FRAC_W + 1;
    localparam int OPA_W      = ((WGT_W > COORD_W) ? WGT_W : COORD_W) + 1;
    localparam int OPB_W      = WGT_W;
    localparam int PROD_W     = OPA_W + OPB_W + 1;
    localparam int ROW_W      = NUM_AXES * COORD_W;

    localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << FRAC_W;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic [IDX_W-1:0]           point_index;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
        logic [PARAM_W-1:0]         param_u;
        logic [PARAM_W-1:0]         param_v;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  surf_x;
        logic signed [COORD_W-1:0]  surf_y;
        logic signed [COORD_W-1:0]  surf_z;
    } res_t;

    // Where a product goes when it comes back from the multiplier
    typedef enum logic [1:0] {
        MK_SQ   = 2'd0,
        MK_CUBE = 2'd1,
        MK_PAIR = 2'd2,
        MK_ACC  = 2'd3
    } mul_kind_t;

    typedef struct packed {
        mul_kind_t   kind;
        logic [2:0]  sel;
    } mul_tag_t;

    typedef struct packed {
        logic                       start;
        mul_tag_t                   tag;
        logic signed [OPA_W-1:0]    a;
        logic [OPB_W-1:0]           b;
    } mul_req_t;

    typedef struct packed {
        logic                       done;
        mul_tag_t                   tag;
        logic signed [PROD_W-1:0]   prod;
    } mul_rsp_t;

    typedef struct packed {
        logic                       en;
        logic [IDX_W-1:0]           idx;
        logic [ROW_W-1:0]           data;
    } store_wr_t;

endpackage

@@ rtl/core/bbp_store.sv @@
// Control point store: 16 rows of x,y,z with per-row valid bits, registered read.
module bbp_store
    import bbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  store_wr_t         wr,
    input  logic [IDX_W-1:0]  raddr,
    output logic [ROW_W-1:0]  rdata
);

    logic [ROW_W-1:0]      mem [NUM_POINTS];
    logic [NUM_POINTS-1:0] valid_reg;
    logic [ROW_W-1:0]      rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
        // a row never written reads as zero
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/bbp_mul.sv @@
// Shared signed-by-unsigned multiplier with registered product and destination tag.
module bbp_mul
    import bbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mul_req_t  req,
    output mul_rsp_t  rsp
);

    logic signed [OPB_W:0]    b_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    mul_tag_t                 tag_reg;
    logic                     done_reg;

    assign b_s       = $signed({1'b0, req.b});
    assign prod_next = req.a * b_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req.start;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        tag_reg  <= req.tag;
    end

    assign rsp.done = done_reg;
    assign rsp.tag  = tag_reg;
    assign rsp.prod = prod_reg;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> rsp.done)
        else $error("product not returned one cycle after issue");

    a_tag_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> rsp.tag == $past(req.tag))
        else $error("product returned with wrong destination tag");

endmodule

@@ rtl/core/bbp_seq.sv @@
// Sequencer: handshakes, Bernstein weights, pair weights and the three coordinate sums.
module bbp_seq
    import bbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    output store_wr_t         store_wr,
    output logic [IDX_W-1:0]  store_raddr,
    input  logic [ROW_W-1:0]  store_rdata,
    output mul_req_t          mul_req,
    input  mul_rsp_t          mul_rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_SQ_WAIT,
        S_CUBE,
        S_CUBE_WAIT,
        S_PAIR,
        S_PAIR_WAIT,
        S_COORD,
        S_DRAIN,
        S_OUT
    } state_t;

    localparam logic [2:0]       SQ_LAST    = 3'd3;
    localparam logic [2:0]       CUBE_LAST  = 3'd7;
    localparam logic [2:0]       AXIS_LAST  = 3'(NUM_AXES - 1);
    localparam logic [IDX_W-1:0] POINT_LAST = IDX_W'(NUM_POINTS - 1);

    state_t                    state_reg, state_next;
    logic [2:0]                step_reg, step_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [PARAM_W-1:0]        t_reg [2], t_next [2];
    logic [PARAM_W-1:0]        s_reg [2], s_next [2];
    logic [PARAM3_W-1:0]       t3_reg [2], t3_next [2];
    logic [PARAM3_W-1:0]       s3_reg [2], s3_next [2];
    logic [WGT_W-1:0]          ss_reg [2], ss_next [2];
    logic [WGT_W-1:0]          tt_reg [2], tt_next [2];
    logic [WGT_W-1:0]          wu_reg [4], wu_next [4];
    logic [WGT_W-1:0]          wv_reg [4], wv_next [4];
    logic [WGT_W-1:0]          pw_reg, pw_next;
    logic signed [PROD_W-1:0]  acc_reg [NUM_AXES], acc_next [NUM_AXES];
    logic                      res_valid_reg, res_valid_next;
    res_t                      res_reg, res_next;

    logic                      accept;
    logic [PARAM_W-1:0]        u_sat, v_sat;
    logic [PARAM_W-1:0]        sq_op;
    logic                      cp;
    logic [COORD_W-1:0]        coord;

    assign cmd_ready   = (state_reg == S_IDLE);
    assign accept      = cmd_valid && cmd_ready;
    assign store_raddr = idx_reg;
    assign res_valid   = res_valid_reg;
    assign res         = res_reg;

    // clamp parameters above one
    assign u_sat = (cmd.param_u > PARAM_ONE) ? PARAM_ONE : cmd.param_u;
    assign v_sat = (cmd.param_v > PARAM_ONE) ? PARAM_ONE : cmd.param_v;

    assign store_wr.en   = accept && (cmd.opcode == OP_LOAD);
    assign store_wr.idx  = cmd.point_index;
    assign store_wr.data = {cmd.coord_z, cmd.coord_y, cmd.coord_x};

    assign cp    = step_reg[2];
    assign sq_op = step_reg[0] ? t_reg[step_reg[1]] : s_reg[step_reg[1]];
    assign coord = store_rdata[step_reg[AXIS_W-1:0] * COORD_W +: COORD_W];

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_req.start    = 1'b0;
        mul_req.tag.kind = MK_SQ;
        mul_req.tag.sel  = step_reg;
        mul_req.a        = '0;
        mul_req.b        = '0;
        case (state_reg)
            S_SQ:
            begin
                mul_req.start    = 1'b1;
                mul_req.tag.kind = MK_SQ;
                mul_req.a        = $signed(OPA_W'(sq_op));
                mul_req.b        = OPB_W'(sq_op);
            end
            S_CUBE:
            begin
                mul_req.start    = 1'b1;
                mul_req.tag.kind = MK_CUBE;
                case (step_reg[1:0])
                    2'd0:
                    begin
                        mul_req.a = $signed(OPA_W'(ss_reg[cp]));
                        mul_req.b = OPB_W'(s_reg[cp]);
                    end
                    2'd1:
                    begin
                        mul_req.a = $signed(OPA_W'(ss_reg[cp]));
                        mul_req.b = OPB_W'(t3_reg[cp]);
                    end
                    2'd2:
                    begin
                        mul_req.a = $signed(OPA_W'(tt_reg[cp]));
                        mul_req.b = OPB_W'(s3_reg[cp]);
                    end
                    default:
                    begin
                        mul_req.a = $signed(OPA_W'(tt_reg[cp]));
                        mul_req.b = OPB_W'(t_reg[cp]);
                    end
                endcase
            end
            S_PAIR:
            begin
                mul_req.start    = 1'b1;
                mul_req.tag.kind = MK_PAIR;
                mul_req.a        = $signed(OPA_W'(wv_reg[idx_reg[3:2]]));
                mul_req.b        = OPB_W'(wu_reg[idx_reg[1:0]]);
            end
            S_COORD:
            begin
                mul_req.start    = 1'b1;
                mul_req.tag.kind = MK_ACC;
                mul_req.a        = OPA_W'($signed(coord));
                mul_req.b        = pw_reg;
            end
            default:
            begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        t3_next        = t3_reg;
        s3_next        = s3_reg;
        ss_next        = ss_reg;
        tt_next        = tt_reg;
        wu_next        = wu_reg;
        wv_next        = wv_reg;
        pw_next        = pw_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        // write back the product that returns this cycle
        if (mul_rsp.done)
        begin
            unique case (mul_rsp.tag.kind)
                MK_SQ:
                begin
                    if (mul_rsp.tag.sel[0])
                    begin
                        tt_next[mul_rsp.tag.sel[1]] = mul_rsp.prod[WGT_W-1:0];
                    end
                    else
                    begin
                        ss_next[mul_rsp.tag.sel[1]] = mul_rsp.prod[WGT_W-1:0];
                    end
                end
                MK_CUBE:
                begin
                    if (mul_rsp.tag.sel[2])
                    begin
                        wv_next[mul_rsp.tag.sel[1:0]] = mul_rsp.prod[FRAC_W +: WGT_W];
                    end
                    else
                    begin
                        wu_next[mul_rsp.tag.sel[1:0]] = mul_rsp.prod[FRAC_W +: WGT_W];
                    end
                end
                MK_PAIR:
                begin
                    pw_next = mul_rsp.prod[2 * FRAC_W +: WGT_W];
                end
                MK_ACC:
                begin
                    acc_next[mul_rsp.tag.sel[AXIS_W-1:0]] =
                        acc_reg[mul_rsp.tag.sel[AXIS_W-1:0]] + mul_rsp.prod;
                end
                default:
                begin
                    pw_next = pw_reg;
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.opcode == OP_EVAL))
                begin
                    t_next[0]  = u_sat;
                    t_next[1]  = v_sat;
                    s_next[0]  = PARAM_ONE - u_sat;
                    s_next[1]  = PARAM_ONE - v_sat;
                    t3_next[0] = (PARAM3_W'(u_sat) << 1) + PARAM3_W'(u_sat);
                    t3_next[1] = (PARAM3_W'(v_sat) << 1) + PARAM3_W'(v_sat);
                    s3_next[0] = (PARAM3_W'(PARAM_ONE - u_sat) << 1)
                               + PARAM3_W'(PARAM_ONE - u_sat);
                    s3_next[1] = (PARAM3_W'(PARAM_ONE - v_sat) << 1)
                               + PARAM3_W'(PARAM_ONE - v_sat);
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        acc_next[i] = '0;
                    end
                    step_next  = '0;
                    idx_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (step_reg == SQ_LAST)
                begin
                    step_next  = '0;
                    state_next = S_SQ_WAIT;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_SQ_WAIT:
            begin
                state_next = S_CUBE;
            end
            S_CUBE:
            begin
                if (step_reg == CUBE_LAST)
                begin
                    step_next  = '0;
                    state_next = S_CUBE_WAIT;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_CUBE_WAIT:
            begin
                state_next = S_PAIR;
            end
            S_PAIR:
            begin
                state_next = S_PAIR_WAIT;
            end
            S_PAIR_WAIT:
            begin
                step_next  = '0;
                state_next = S_COORD;
            end
            S_COORD:
            begin
                if (step_reg == AXIS_LAST)
                begin
                    step_next = '0;
                    if (idx_reg == POINT_LAST)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_PAIR;
                    end
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the previous result is taken
                if (!res_valid_reg || res_ready)
                begin
                    res_next.surf_x = acc_reg[0][2 * FRAC_W +: COORD_W];
                    res_next.surf_y = acc_reg[1][2 * FRAC_W +: COORD_W];
                    res_next.surf_z = acc_reg[2][2 * FRAC_W +: COORD_W];
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            pw_reg        <= '0;
            for (int i = 0; i < 2; i++)
            begin
                t_reg[i]  <= '0;
                s_reg[i]  <= '0;
                t3_reg[i] <= '0;
                s3_reg[i] <= '0;
                ss_reg[i] <= '0;
                tt_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                wu_reg[i] <= '0;
                wv_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_AXES; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
            pw_reg        <= pw_next;
            t_reg         <= t_next;
            s_reg         <= s_next;
            t3_reg        <= t3_next;
            s3_reg        <= s3_next;
            ss_reg        <= ss_next;
            tt_reg        <= tt_next;
            wu_reg        <= wu_next;
            wv_reg        <= wv_next;
            acc_reg       <= acc_next;
        end
    end

    a_eval_starts_squares: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.opcode == OP_EVAL) |=> state_reg == S_SQ)
        else $error("evaluate item did not start the weight sequence");

    a_sq_done_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done && (mul_rsp.tag.kind == MK_SQ)
            |-> (state_reg == S_SQ) || (state_reg == S_SQ_WAIT))
        else $error("square product returned outside the square phase");

    a_pair_done_before_coords: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done && (mul_rsp.tag.kind == MK_PAIR) |-> state_reg == S_PAIR_WAIT)
        else $error("pair weight returned out of step with coordinate products");

    a_drained_at_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) || (state_reg == S_IDLE) |-> !mul_rsp.done)
        else $error("product still in flight when the sums are read");

endmodule

@@ rtl/core/bicubic_bezier_patch_eval_core.sv @@
// Top level of the bicubic Bezier patch evaluator: store, shared multiplier and sequencer.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one item at a time. A load item
//   (opcode OP_LOAD) writes control point point_index (4*row+col) with x,y,z and
//   produces no result; cmd_ready stays high, so the block is ready for another item.
//   An evaluate item (OP_EVAL) produces one res item with surf_x/y/z, the surface
//   point at (param_u, param_v); parameters above 1.0 are clamped to 1.0.
//   Evaluate runs on one shared multiplier with a registered product: 4 squares,
//   8 cube terms, then 16 pair weights each followed by 3 coordinate products,
//   one product issued per cycle, with a wait state after each dependent group.
//   The result is registered and cmd_ready returns at the same edge, as the
//   sequencer leaves its output step; a new evaluate is not accepted before that.
//   cmd_ready is low for the whole evaluation.
//   res is held in an output register: a new item is accepted while a result is
//   waiting, and a finished evaluation holds in its last step until the waiting
//   result has been taken.
//   Reset (rst_n low, asynchronous) clears the sequencer and output valid, and
//   marks all control points unwritten; unwritten points read as zero.
module bicubic_bezier_patch_eval_core
    import bbp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_valid,
    output logic  cmd_ready,
    input  cmd_t  cmd,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res
);

    store_wr_t         store_wr;
    logic [IDX_W-1:0]  store_raddr;
    logic [ROW_W-1:0]  store_rdata;
    mul_req_t          mul_req;
    mul_rsp_t          mul_rsp;

    // control points, one row of x,y,z per point
    bbp_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (store_wr),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // the one multiplier all products go through
    bbp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // handshakes, operand selection, weight and sum registers
    bbp_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .store_wr    (store_wr),
        .store_raddr (store_raddr),
        .store_rdata (store_rdata),
        .mul_req     (mul_req),
        .mul_rsp     (mul_rsp)
    );

endmodule
